>>> hw/rtl/ncis_pkg.sv
// shared types and constants of the nibble cpu instruction step core
package ncis_pkg;

   localparam int NibWidth = 4;
   localparam int LocWidth = 8;
   localparam int PcWidth  = 8;
   localparam int MemDepth = 1 << LocWidth;

   // stores below this nibble address touch the screen area
   localparam logic [LocWidth-1:0] ScreenLimit = LocWidth'(4);

   localparam logic [LocWidth-1:0] HighNibMask = 8'hF0;
   localparam logic [LocWidth-1:0] LowNibMask  = 8'h0F;

   typedef enum logic [NibWidth-1:0] {
      OP_NOP       = 4'd0,
      OP_ADD       = 4'd1,
      OP_SUB       = 4'd2,
      OP_LOC_HIGH  = 4'd3,
      OP_LOC_LOW   = 4'd4,
      OP_SET_X     = 4'd5,
      OP_SET_Y     = 4'd6,
      OP_SET_Z     = 4'd7,
      OP_STORE     = 4'd8,
      OP_LOAD_Z    = 4'd9,
      OP_JMP_LOW   = 4'd10,
      OP_JMP_HIGH  = 4'd11,
      OP_JUMP      = 4'd12,
      OP_LOAD_X    = 4'd13,
      OP_LOAD_Y    = 4'd14,
      OP_TOG_CARRY = 4'd15
   } opcode_type;

   typedef struct packed {
      logic [PcWidth-1:0]  next_pc;
      logic [NibWidth-1:0] reg_x;
      logic [NibWidth-1:0] reg_y;
      logic [NibWidth-1:0] reg_z;
      logic                carry_flag;
      logic                carry_in_enabled;
      logic [LocWidth-1:0] location;
      logic                memory_written;
      logic                screen_changed;
   } rsp_type;

endpackage

>>> hw/rtl/ncis_ram.sv
// generic single write port ram with one registered read port
module ncis_ram #(
   parameter int Width = 4,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read, read returns old data on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/nibble_cpu_instruction_step_core.sv
// top level of the nibble cpu instruction step core
//
// Executes one instruction of a small 4-bit processor per accepted item.
// Request channel: req_opcode and req_immediate, taken at an edge where
// req_valid is high and req_stall is low. Response channel: one item per
// request with the next fetch address, the X, Y and Z registers, carry,
// carry-use, location pointer and store flags, taken when rsp_valid is high
// and rsp_stall is low.
// Each result goes to the response register, or to the skid register while
// a response is held. Throughput is one item per cycle while req_stall is
// low; all the work happens between the request ports and the response
// register, and the data memory read port is kept pointed at the next
// location pointer, so a load finds its nibble waiting in the ram read
// register. When the receiver stalls, the held response stays put and one
// more item is taken into a skid register; req_stall rises only while that
// is full. Synchronous reset clears the state registers, the response and
// skid valid bits and the 256 valid bits of the data memory at once, so the
// memory reads as zero right after reset with no clearing pass.
module nibble_cpu_instruction_step_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ncis_pkg::NibWidth-1:0] req_opcode,
   input  logic [ncis_pkg::NibWidth-1:0] req_immediate,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ncis_pkg::PcWidth-1:0]  rsp_next_pc,
   output logic [ncis_pkg::NibWidth-1:0] rsp_reg_x,
   output logic [ncis_pkg::NibWidth-1:0] rsp_reg_y,
   output logic [ncis_pkg::NibWidth-1:0] rsp_reg_z,
   output logic                          rsp_carry_flag,
   output logic                          rsp_carry_in_enabled,
   output logic [ncis_pkg::LocWidth-1:0] rsp_location,
   output logic                          rsp_memory_written,
   output logic                          rsp_screen_changed
);
   import ncis_pkg::*;

   // architectural state
   logic [PcWidth-1:0]  pc_ff, pc_in;
   logic [LocWidth-1:0] jt_ff, jt_in;
   logic [LocWidth-1:0] loc_ff, loc_in, loc_new;
   logic [NibWidth-1:0] x_ff, x_in;
   logic [NibWidth-1:0] y_ff, y_in;
   logic [NibWidth-1:0] z_ff, z_in;
   logic                carry_ff, carry_in;
   logic                cuse_ff, cuse_in;
   logic [MemDepth-1:0] valid_ff, valid_in;
   logic                byp_ff;
   logic [NibWidth-1:0] byp_data_ff;

   // response and skid stages
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_v_ff, out_v_in;
   logic    skid_v_ff, skid_v_in;

   logic                accept;
   logic                take;
   logic                wr_en;
   logic [NibWidth-1:0] ram_q;
   logic [NibWidth-1:0] mem_q;
   logic                cin;
   logic [NibWidth:0]   sum;
   logic [NibWidth:0]   subtrahend;
   logic [NibWidth:0]   diff;
   logic [LocWidth-1:0] jt_dec;
   logic [LocWidth-1:0] imm_wide;
   rsp_type             result;

   assign accept = req_valid && !skid_v_ff;
   assign take   = out_v_ff && !rsp_stall;

   // data memory, read address follows the pointer the next item will see
   assign wr_en = accept && (opcode_type'(req_opcode) == OP_STORE);

   ncis_ram #(
      .Width (NibWidth),
      .Depth (MemDepth)
   ) u_data_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (loc_ff),
      .wr_data (z_ff),
      .rd_addr (loc_in),
      .rd_data (ram_q)
   );

   // nibble at the current pointer: unwritten reads zero, fresh store bypassed
   always_comb begin
      if (!valid_ff[loc_ff]) begin
         mem_q = '0;
      end else if (byp_ff) begin
         mem_q = byp_data_ff;
      end else begin
         mem_q = ram_q;
      end
   end

   // alu
   assign cin        = cuse_ff & carry_ff;
   assign sum        = {1'b0, x_ff} + {1'b0, y_ff} + {{NibWidth{1'b0}}, cin};
   assign subtrahend = {1'b0, y_ff} + {{NibWidth{1'b0}}, cin};
   assign diff       = {1'b0, x_ff} - subtrahend;
   assign jt_dec     = jt_ff - LocWidth'(1);
   assign imm_wide   = {{(LocWidth-NibWidth){1'b0}}, req_immediate};

   // instruction execute
   always_comb begin
      pc_in    = pc_ff + PcWidth'(1);
      jt_in    = jt_ff;
      loc_new  = loc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      carry_in = carry_ff;
      cuse_in  = cuse_ff;
      case (opcode_type'(req_opcode))
         OP_NOP: begin
         end
         OP_ADD: begin
            z_in     = sum[NibWidth-1:0];
            carry_in = sum[NibWidth];
         end
         OP_SUB: begin
            z_in     = diff[NibWidth-1:0];
            carry_in = ~diff[NibWidth];
         end
         OP_LOC_HIGH: loc_new = (loc_ff & LowNibMask) | (imm_wide << NibWidth);
         OP_LOC_LOW:  loc_new = (loc_ff & HighNibMask) | imm_wide;
         OP_SET_X:    x_in = req_immediate;
         OP_SET_Y:    y_in = req_immediate;
         OP_SET_Z:    z_in = req_immediate;
         OP_STORE: begin
         end
         OP_LOAD_Z:   z_in = mem_q;
         OP_JMP_LOW:  jt_in = (jt_ff & HighNibMask) | imm_wide;
         OP_JMP_HIGH: jt_in = (jt_ff & LowNibMask) | (imm_wide << NibWidth);
         OP_JUMP: begin
            // target steps back and stays so, pc lands on the old target
            jt_in = jt_dec;
            pc_in = jt_ff;
         end
         OP_LOAD_X:    x_in = mem_q;
         OP_LOAD_Y:    y_in = mem_q;
         OP_TOG_CARRY: cuse_in = ~cuse_ff;
         default: begin
         end
      endcase
   end

   assign loc_in = accept ? loc_new : loc_ff;

   // response item of this instruction
   always_comb begin
      result.next_pc          = pc_in;
      result.reg_x            = x_in;
      result.reg_y            = y_in;
      result.reg_z            = z_in;
      result.carry_flag       = carry_in;
      result.carry_in_enabled = cuse_in;
      result.location         = loc_new;
      result.memory_written   = wr_en;
      result.screen_changed   = wr_en && (loc_ff < ScreenLimit);
   end

   // valid bits of the data memory
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[loc_ff] = 1'b1;
      end
   end

   // response register with skid stage
   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (take || !out_v_ff) begin
         if (skid_v_ff) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_v_in = 1'b0;
         end else begin
            out_in   = result;
            out_v_in = accept;
         end
      end else if (accept) begin
         skid_in   = result;
         skid_v_in = 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         jt_ff     <= '0;
         loc_ff    <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         z_ff      <= '0;
         carry_ff  <= 1'b0;
         cuse_ff   <= 1'b0;
         valid_ff  <= '0;
         byp_ff    <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (accept) begin
            pc_ff    <= pc_in;
            jt_ff    <= jt_in;
            loc_ff   <= loc_new;
            x_ff     <= x_in;
            y_ff     <= y_in;
            z_ff     <= z_in;
            carry_ff <= carry_in;
            cuse_ff  <= cuse_in;
         end
         valid_ff  <= valid_in;
         // a store hits the address being read, the ram returns stale data once
         byp_ff    <= wr_en;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byp_data_ff <= z_ff;
      out_ff      <= out_in;
      skid_ff     <= skid_in;
   end

   assign req_stall            = skid_v_ff;
   assign rsp_valid            = out_v_ff;
   assign rsp_next_pc          = out_ff.next_pc;
   assign rsp_reg_x            = out_ff.reg_x;
   assign rsp_reg_y            = out_ff.reg_y;
   assign rsp_reg_z            = out_ff.reg_z;
   assign rsp_carry_flag       = out_ff.carry_flag;
   assign rsp_carry_in_enabled = out_ff.carry_in_enabled;
   assign rsp_location         = out_ff.location;
   assign rsp_memory_written   = out_ff.memory_written;
   assign rsp_screen_changed   = out_ff.screen_changed;

endmodule

>>> hw/rtl/ncis_checker.sv
// port level checker of the nibble cpu instruction step core and its bind
module ncis_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ncis_pkg::PcWidth-1:0]  rsp_next_pc,
   input logic                          rsp_memory_written,
   input logic                          rsp_screen_changed
);
   import ncis_pkg::*;

   // reset empties the response stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the skid stage fills only behind a held response
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // after every accepted item a response is valid in the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no response");

   // a screen update is always a store
   a_screen_is_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_screen_changed) |-> rsp_memory_written)
      else $error("screen change without a store");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_next_pc)))
      else $error("stalled response changed");

endmodule

bind nibble_cpu_instruction_step_core ncis_checker u_ncis_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_next_pc        (rsp_next_pc),
   .rsp_memory_written (rsp_memory_written),
   .rsp_screen_changed (rsp_screen_changed)
);
